[hdl/mcf_pkg.sv]
// Shared types and constants for the message chunk framer.
`timescale 1ns / 1ps

package mcf_pkg;

  // Header layout and limits.
  localparam int unsigned HEADER_BYTES = 10;
  localparam int unsigned CHUNK_LIMIT  = 99;
  localparam int unsigned IDENT_MAX    = 9999;
  localparam int unsigned TTL_MAX      = 99;

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 18;
  localparam int unsigned IDENT_W = 14;
  localparam int unsigned MTU_W   = 11;
  localparam int unsigned HOP_W   = 7;
  localparam int unsigned CHUNK_W = 7;
  localparam int unsigned ERR_W   = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = MTU_W;
  localparam logic [CFG_IDX_W-1:0] CFG_MTU = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP = 1'd1;

  localparam logic [MTU_W-1:0] MTU_RESET = 11'd512;
  localparam logic [HOP_W-1:0] HOP_RESET = 7'd0;

  // Error codes.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_IDENT = 2'd1,
    ERR_COUNT = 2'd2
  } err_code_t;

  // Input request.
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [LEN_W-1:0]   message_length;
    logic [IDENT_W-1:0] packet_ident;
  } in_item_t;

  // Result request.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_header;
    logic              chunk_end;
    logic              message_end;
    logic [ERR_W-1:0]  error_code;
  } out_item_t;

endpackage

[hdl/message_chunk_framer_top.sv]
// Message chunk framer: splits a byte stream into chunks with ASCII headers.
`timescale 1ns / 1ps

// The block takes one payload byte per input request and returns its results
// through a registered output, so a new request is taken while the previous
// result still waits. A byte inside an open chunk goes straight to its payload
// result. The first byte of each later chunk is preceded by its header digits.
// The first byte of a message also runs the chunk count division on a shared
// 14-bit subtractor, then the decimal split of the packet id on the same
// subtractor, and then its own header digits. A message with a bad packet id
// skips both and gives a single error result; one with too many chunks gives it
// after the division. Bytes of a dropped message are taken and give nothing.
module message_chunk_framer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mcf_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mcf_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [mcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_HDR,
    ST_PAY,
    ST_ERR
  } state_t;

  localparam int unsigned SUB_W  = mcf_pkg::IDENT_W;
  localparam int unsigned STEP_W = $clog2(mcf_pkg::LEN_W);
  localparam int unsigned HCNT_W = $clog2(mcf_pkg::HEADER_BYTES);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(mcf_pkg::LEN_W - 1);
  localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(mcf_pkg::HEADER_BYTES - 1);
  localparam logic [mcf_pkg::MTU_W-1:0] MTU_FLOOR =
    mcf_pkg::MTU_W'(2 * mcf_pkg::HEADER_BYTES);
  localparam logic [mcf_pkg::MTU_W-1:0] HDR_LEN = mcf_pkg::MTU_W'(mcf_pkg::HEADER_BYTES);

  // Tens digit of a value below one hundred.
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) begin
        t = 4'(k);
      end
    end
    return t;
  endfunction

  // Ones digit of a value below one hundred.
  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] r;
    r = v - 7'(tens_of(v)) * 7'd10;
    return r[3:0];
  endfunction

  state_t                        state_r;
  logic [mcf_pkg::MTU_W-1:0]     mtu_r;
  logic [mcf_pkg::HOP_W-1:0]     hop_r;

  // Message state.
  logic [mcf_pkg::LEN_W-1:0]     byte_pos_r;
  logic [mcf_pkg::MTU_W-1:0]     chunk_fill_r;
  logic [mcf_pkg::CHUNK_W-1:0]   chunk_idx_r;
  logic [mcf_pkg::CHUNK_W-1:0]   chunk_tot_r;
  logic                          drop_r;

  // Request held while it is worked on.
  logic [mcf_pkg::BYTE_W-1:0]    data_r;
  logic                          last_r;
  logic [mcf_pkg::ERR_W-1:0]     err_r;

  // Sequencer working registers.
  logic [mcf_pkg::LEN_W-1:0]     div_num_r;
  logic [mcf_pkg::MTU_W-1:0]     div_rem_r;
  logic [mcf_pkg::LEN_W-1:0]     div_quo_r;
  logic [STEP_W-1:0]             step_r;
  logic [SUB_W-1:0]              id_rem_r;
  logic [3:0]                    dig_r [4];
  logic [1:0]                    dig_sel_r;
  logic [HCNT_W-1:0]             hdr_cnt_r;

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  mcf_pkg::out_item_t            out_data_r;

  logic                          accept;
  logic                          out_free;
  logic                          out_load;
  logic [mcf_pkg::MTU_W-1:0]     cap;
  logic                          last_nxt;
  logic [mcf_pkg::LEN_W-1:0]     len_adj;
  logic [SUB_W-1:0]              sub_a;
  logic [SUB_W-1:0]              sub_b;
  logic [SUB_W:0]                sub_diff;
  logic                          sub_ge;
  logic [mcf_pkg::MTU_W-1:0]     div_rem_nxt;
  logic [mcf_pkg::LEN_W-1:0]     div_quo_nxt;
  logic                          cend;
  logic [7:0]                    num_sum;
  logic [6:0]                    chunk_num;
  logic [6:0]                    ttl;
  logic [3:0]                    hdr_digit;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // A result is loaded in the emitting states whenever the output slot is free.
  assign out_load      = out_free &&
                         (state_r == ST_HDR || state_r == ST_PAY || state_r == ST_ERR);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  // Payload room per chunk, with the smallest chunk size enforced.
  assign cap = (mtu_r < MTU_FLOOR) ? HDR_LEN : (mtu_r - HDR_LEN);

  assign last_nxt = ({1'b0, byte_pos_r} + 19'd1) >= {1'b0, in_data.message_length};
  assign len_adj  = (in_data.message_length == '0) ? mcf_pkg::LEN_W'(1)
                                                   : in_data.message_length;

  // Shared subtractor: division steps and decimal digit steps.
  always_comb begin
    if (state_r == ST_DIV) begin
      sub_a = {2'b00, div_rem_r, div_num_r[mcf_pkg::LEN_W-1]};
      sub_b = SUB_W'(cap);
    end else begin
      sub_a = id_rem_r;
      case (dig_sel_r)
        2'd0:    sub_b = SUB_W'(1000);
        2'd1:    sub_b = SUB_W'(100);
        default: sub_b = SUB_W'(10);
      endcase
    end
  end

  assign sub_diff    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge      = !sub_diff[SUB_W];
  assign div_rem_nxt = sub_ge ? sub_diff[mcf_pkg::MTU_W-1:0] : sub_a[mcf_pkg::MTU_W-1:0];
  assign div_quo_nxt = {div_quo_r[mcf_pkg::LEN_W-2:0], sub_ge};

  // Chunk close test for the held payload byte.
  assign cend = last_r || (({1'b0, chunk_fill_r} + 12'd1) >= {1'b0, cap});

  // Header digit selection.
  assign num_sum   = {1'b0, chunk_idx_r} + 8'd1;
  assign chunk_num = (num_sum >= 8'd100) ? 7'(num_sum - 8'd100) : num_sum[6:0];
  assign ttl       = (hop_r > 7'(mcf_pkg::TTL_MAX)) ? 7'(mcf_pkg::TTL_MAX) : hop_r;

  always_comb begin
    case (hdr_cnt_r)
      4'd0:    hdr_digit = dig_r[0];
      4'd1:    hdr_digit = dig_r[1];
      4'd2:    hdr_digit = dig_r[2];
      4'd3:    hdr_digit = dig_r[3];
      4'd4:    hdr_digit = tens_of(chunk_num);
      4'd5:    hdr_digit = ones_of(chunk_num);
      4'd6:    hdr_digit = tens_of(chunk_tot_r);
      4'd7:    hdr_digit = ones_of(chunk_tot_r);
      4'd8:    hdr_digit = tens_of(ttl);
      default: hdr_digit = ones_of(ttl);
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r <= mcf_pkg::MTU_RESET;
      hop_r <= mcf_pkg::HOP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcf_pkg::CFG_MTU: mtu_r <= cfg_wdata;
        mcf_pkg::CFG_HOP: hop_r <= cfg_wdata[mcf_pkg::HOP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, message state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      byte_pos_r   <= '0;
      chunk_fill_r <= '0;
      chunk_idx_r  <= '0;
      chunk_tot_r  <= '0;
      drop_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            data_r   <= in_data.data_byte;
            last_r   <= last_nxt;
            id_rem_r <= in_data.packet_ident;
            if (byte_pos_r == '0) begin
              if (in_data.packet_ident > SUB_W'(mcf_pkg::IDENT_MAX)) begin
                err_r   <= mcf_pkg::ERR_IDENT;
                state_r <= ST_ERR;
              end else begin
                div_num_r <= len_adj - mcf_pkg::LEN_W'(1);
                div_rem_r <= '0;
                div_quo_r <= '0;
                step_r    <= STEP_LAST;
                state_r   <= ST_DIV;
              end
            end else if (drop_r) begin
              // Bytes of a dropped message are consumed silently.
              if (last_nxt) begin
                byte_pos_r <= '0;
                drop_r     <= 1'b0;
              end else begin
                byte_pos_r <= byte_pos_r + mcf_pkg::LEN_W'(1);
              end
            end else if (chunk_fill_r == '0) begin
              hdr_cnt_r <= '0;
              state_r   <= ST_HDR;
            end else begin
              state_r <= ST_PAY;
            end
          end
        end

        // One restoring division step per cycle: (length - 1) / cap.
        ST_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_num_r <= {div_num_r[mcf_pkg::LEN_W-2:0], 1'b0};
          step_r    <= step_r - STEP_W'(1);
          if (step_r == '0) begin
            if (div_quo_nxt >= mcf_pkg::LEN_W'(mcf_pkg::CHUNK_LIMIT)) begin
              err_r   <= mcf_pkg::ERR_COUNT;
              state_r <= ST_ERR;
            end else begin
              chunk_tot_r  <= div_quo_nxt[mcf_pkg::CHUNK_W-1:0] + mcf_pkg::CHUNK_W'(1);
              chunk_fill_r <= '0;
              chunk_idx_r  <= '0;
              for (int k = 0; k < 4; k++) begin
                dig_r[k] <= 4'd0;
              end
              dig_sel_r <= 2'd0;
              state_r   <= ST_DIGIT;
            end
          end
        end

        // Decimal split of the packet id by repeated subtraction.
        ST_DIGIT: begin
          if (sub_ge) begin
            id_rem_r         <= sub_diff[SUB_W-1:0];
            dig_r[dig_sel_r] <= dig_r[dig_sel_r] + 4'd1;
          end else if (dig_sel_r == 2'd2) begin
            dig_r[3]  <= id_rem_r[3:0];
            hdr_cnt_r <= '0;
            state_r   <= ST_HDR;
          end else begin
            dig_sel_r <= dig_sel_r + 2'd1;
          end
        end

        // Header digits, one per free output slot.
        ST_HDR: begin
          if (out_free) begin
            out_data_r.out_byte    <= 8'h30 + {4'd0, hdr_digit};
            out_data_r.is_header   <= 1'b1;
            out_data_r.chunk_end   <= 1'b0;
            out_data_r.message_end <= 1'b0;
            out_data_r.error_code  <= mcf_pkg::ERR_NONE;
            hdr_cnt_r              <= hdr_cnt_r + HCNT_W'(1);
            if (hdr_cnt_r == HCNT_LAST) begin
              state_r <= ST_PAY;
            end
          end
        end

        // The payload byte itself, then the chunk and message counters.
        ST_PAY: begin
          if (out_free) begin
            out_data_r.out_byte    <= data_r;
            out_data_r.is_header   <= 1'b0;
            out_data_r.chunk_end   <= cend;
            out_data_r.message_end <= last_r;
            out_data_r.error_code  <= mcf_pkg::ERR_NONE;
            if (last_r) begin
              byte_pos_r   <= '0;
              chunk_fill_r <= '0;
              chunk_idx_r  <= '0;
              chunk_tot_r  <= '0;
            end else begin
              byte_pos_r <= byte_pos_r + mcf_pkg::LEN_W'(1);
              if (cend) begin
                chunk_fill_r <= '0;
                chunk_idx_r  <= chunk_idx_r + mcf_pkg::CHUNK_W'(1);
              end else begin
                chunk_fill_r <= chunk_fill_r + mcf_pkg::MTU_W'(1);
              end
            end
            state_r <= ST_IDLE;
          end
        end

        // Single error request; the rest of the message is dropped.
        ST_ERR: begin
          if (out_free) begin
            out_data_r.out_byte    <= '0;
            out_data_r.is_header   <= 1'b0;
            out_data_r.chunk_end   <= 1'b0;
            out_data_r.message_end <= 1'b0;
            out_data_r.error_code  <= err_r;
            chunk_fill_r           <= '0;
            chunk_idx_r            <= '0;
            chunk_tot_r            <= '0;
            if (last_r) begin
              byte_pos_r <= '0;
              drop_r     <= 1'b0;
            end else begin
              byte_pos_r <= mcf_pkg::LEN_W'(1);
              drop_r     <= 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
